/* rtl/core/cti_pkg.sv */
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants for the trapezoid integrator.
// ----------------------------------------------------------------------------
package cti_pkg;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_N    = 2'd1,
        STATUS_ZERO_LEN = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENDS,
        ST_XDIV,
        ST_SQ,
        ST_ACC,
        ST_AREA_MUL,
        ST_AREA_DIV,
        ST_CHG_MUL,
        ST_CHG_DIV,
        ST_PCT_MUL,
        ST_PCT_DIV,
        ST_DONE
    } state_t;

    localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
    localparam logic [63:0] MAX63     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PCT_SCALE = 64'd6553600;

endpackage

/* rtl/core/composite_trapezoid_integrator.sv */
// ----------------------------------------------------------------------------
// composite_trapezoid_integrator
// Composite trapezoid integral of x*x+1 with a shared multiplier and a shared
// bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Each interior point takes a 44-step serial division for i*D/n, a 4-step
// partial-product square and one accumulate; then up to three 4-step
// multiplies and three 128-step divisions. Rejected requests answer in the
// cycle after the beat. One beat at a time; no new beat until the result is
// taken. Reset (aresetn, synchronous) returns the sequencer to idle.
module composite_trapezoid_integrator #(
    parameter int MAX_INTERVALS = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_lower_limit,
    input  logic signed [31:0]  s_upper_limit,
    input  logic [12:0]         s_interval_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_integral_value,
    output logic [62:0]         m_last_abs_change,
    output logic [31:0]         m_last_pct_change,
    output logic [1:0]          m_status
);
    import cti_pkg::*;

    localparam int NW = $clog2(MAX_INTERVALS + 1);

    state_t state_reg, state_next;

    logic signed [32:0] lo_reg;
    logic [32:0]        d_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      i_reg;
    logic               neg_reg;
    logic [63:0]        s_reg;
    logic [63:0]        flast_reg;
    logic [63:0]        mag_reg;
    logic [63:0]        chg_reg;
    logic               endb_reg;

    // shared square unit (4 partial products of 17x17)
    logic [32:0]        sqm_reg;
    logic [65:0]        sqp_reg;
    logic [1:0]         sqk_reg;

    // shared divider: 128-bit numerator / 64-bit divisor
    logic [127:0]       num_reg;
    logic [63:0]        den_reg;
    logic [64:0]        rem_reg;
    logic [7:0]         cnt_reg;

    // 64x64 multiply as four 32x32 products over cycles
    logic [63:0]        ma_reg, mb_reg;
    logic [127:0]       prod_reg;
    logic [1:0]         mk_reg;

    logic [63:0]        out_int_reg;
    logic [62:0]        out_abs_reg;
    logic [31:0]        out_pct_reg;
    status_t            out_st_reg;
    logic               mv_reg;

    logic [64:0] rem_sh;
    logic        qbit;
    logic [64:0] rem_new;
    logic [31:0] ma_part, mb_part;
    logic [63:0] mpp;
    logic [16:0] sq_a, sq_b;
    logic [33:0] sqpp;
    logic [63:0] fval;
    logic signed [32:0] xval;
    logic        s_accept;
    logic        s_reject;

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_integral_value  = out_int_reg;
    assign m_last_abs_change = out_abs_reg;
    assign m_last_pct_change = out_pct_reg;
    assign m_status          = out_st_reg;

    assign s_accept = s_valid && s_ready;
    assign s_reject = (s_interval_count == '0) || (s_lower_limit == s_upper_limit);

    assign rem_sh  = {rem_reg[63:0], num_reg[127]};
    assign qbit    = rem_reg[64] || rem_sh[63:0] >= den_reg || rem_sh[64];
    assign rem_new = qbit ? (rem_sh - {1'b0, den_reg}) : rem_sh;

    always_comb begin
        unique case (mk_reg)
            2'd0: begin ma_part = ma_reg[31:0];  mb_part = mb_reg[31:0];  end
            2'd1: begin ma_part = ma_reg[31:0];  mb_part = mb_reg[63:32]; end
            2'd2: begin ma_part = ma_reg[63:32]; mb_part = mb_reg[31:0];  end
            default: begin ma_part = ma_reg[63:32]; mb_part = mb_reg[63:32]; end
        endcase
    end
    assign mpp = ma_part * mb_part;

    always_comb begin
        unique case (sqk_reg)
            2'd0: begin sq_a = {1'b0, sqm_reg[15:0]}; sq_b = {1'b0, sqm_reg[15:0]}; end
            2'd1: begin sq_a = {1'b0, sqm_reg[15:0]}; sq_b = sqm_reg[32:16]; end
            2'd2: begin sq_a = sqm_reg[32:16]; sq_b = {1'b0, sqm_reg[15:0]}; end
            default: begin sq_a = sqm_reg[32:16]; sq_b = sqm_reg[32:16]; end
        endcase
    end
    assign sqpp = sq_a * sq_b;
    assign fval = 64'(sqp_reg[65:16]) + ONE_Q32;
    assign xval = lo_reg + $signed({1'b0, num_reg[30:0], qbit});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_accept && !s_reject) state_next = ST_ENDS;
            ST_ENDS:     state_next = ST_SQ;
            ST_XDIV:     if (cnt_reg == 8'd0) state_next = ST_SQ;
            ST_SQ:       if (sqk_reg == 2'd3) state_next = ST_ACC;
            ST_ACC: begin
                if (endb_reg)                          state_next = ST_SQ;
                else if (i_reg + NW'(1) == n_reg)      state_next = ST_AREA_MUL;
                else                                   state_next = ST_XDIV;
            end
            ST_AREA_MUL: if (mk_reg == 2'd3) state_next = ST_AREA_DIV;
            ST_AREA_DIV: if (cnt_reg == 8'd0) begin
                if (n_reg >= NW'(3)) state_next = ST_CHG_MUL;
                else                 state_next = ST_DONE;
            end
            ST_CHG_MUL:  if (mk_reg == 2'd3) state_next = ST_CHG_DIV;
            ST_CHG_DIV:  if (cnt_reg == 8'd0) state_next = ST_PCT_MUL;
            ST_PCT_MUL: begin
                if (mag_reg == '0)        state_next = ST_DONE;
                else if (mk_reg == 2'd3)  state_next = ST_PCT_DIV;
            end
            ST_PCT_DIV:  if (cnt_reg == 8'd0) state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE || (s_accept && s_reject))
                mv_reg <= 1'b1;
            else if (mv_reg && m_ready)
                mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    out_int_reg <= '0;
                    out_abs_reg <= '0;
                    out_pct_reg <= '0;
                    out_st_reg  <= STATUS_OK;
                    if (s_interval_count == '0)
                        out_st_reg <= STATUS_BAD_N;
                    else if (s_lower_limit == s_upper_limit)
                        out_st_reg <= STATUS_ZERO_LEN;
                    if (s_lower_limit > s_upper_limit) begin
                        lo_reg  <= 33'(s_upper_limit);
                        d_reg   <= 33'(s_lower_limit) - 33'(s_upper_limit);
                        neg_reg <= 1'b1;
                    end else begin
                        lo_reg  <= 33'(s_lower_limit);
                        d_reg   <= 33'(s_upper_limit) - 33'(s_lower_limit);
                        neg_reg <= 1'b0;
                    end
                    if (32'(s_interval_count) > 32'(MAX_INTERVALS))
                        n_reg <= NW'(MAX_INTERVALS);
                    else
                        n_reg <= NW'(s_interval_count);
                    mag_reg   <= '0;
                    chg_reg   <= '0;
                    flast_reg <= '0;
                end
            end
            ST_ENDS: begin
                s_reg    <= '0;
                i_reg    <= '0;
                endb_reg <= 1'b1;
                sqm_reg  <= lo_reg[32] ? 33'(-lo_reg) : 33'(lo_reg);
                sqp_reg  <= '0;
                sqk_reg  <= '0;
            end
            ST_XDIV: begin
                num_reg <= {num_reg[126:0], qbit};
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd0) begin
                    sqm_reg <= xval[32] ? 33'(-xval) : 33'(xval);
                    sqp_reg <= '0;
                    sqk_reg <= '0;
                end
            end
            ST_SQ: begin
                unique case (sqk_reg)
                    2'd0:    sqp_reg <= sqp_reg + 66'(sqpp);
                    2'd3:    sqp_reg <= sqp_reg + {sqpp, 32'd0};
                    default: sqp_reg <= sqp_reg + {16'd0, sqpp, 16'd0};
                endcase
                sqk_reg <= sqk_reg + 2'd1;
            end
            ST_ACC: begin
                if (endb_reg || i_reg == '0) begin
                    s_reg <= s_reg + fval;
                end else begin
                    s_reg     <= s_reg + {fval[62:0], 1'b0};
                    flast_reg <= fval;
                end
                if (endb_reg) begin
                    endb_reg <= 1'b0;
                    sqm_reg  <= (lo_reg + $signed(d_reg)) < 0 ?
                                33'(-(lo_reg + $signed(d_reg))) :
                                33'(lo_reg + $signed(d_reg));
                    sqp_reg  <= '0;
                    sqk_reg  <= '0;
                end else begin
                    i_reg <= i_reg + NW'(1);
                end
                // setup i*D/n for next point
                num_reg <= {64'd0, 64'(d_reg) * 64'(i_reg + NW'(1))} << 84;
                rem_reg <= '0;
                den_reg <= 64'(n_reg);
                cnt_reg <= 8'd43;
                ma_reg  <= 64'(d_reg);
                mb_reg  <= s_reg + (endb_reg || i_reg == '0 ? fval : {fval[62:0], 1'b0});
                prod_reg <= '0;
                mk_reg   <= '0;
            end
            ST_AREA_MUL, ST_CHG_MUL, ST_PCT_MUL: begin
                unique case (mk_reg)
                    2'd0:    prod_reg <= prod_reg + 128'(mpp);
                    2'd3:    prod_reg <= prod_reg + {mpp, 64'd0};
                    default: prod_reg <= prod_reg + {32'd0, mpp, 32'd0};
                endcase
                mk_reg <= mk_reg + 2'd1;
                if (mk_reg == 2'd3) begin
                    if (state_reg == ST_PCT_MUL) begin
                        num_reg <= prod_reg + {mpp, 64'd0};
                        den_reg <= mag_reg;
                    end else begin
                        num_reg <= (prod_reg + {mpp, 64'd0}) >> 24;
                        den_reg <= 64'({n_reg, 1'b0});
                    end
                    rem_reg <= '0;
                    cnt_reg <= 8'd127;
                end
            end
            ST_AREA_DIV, ST_CHG_DIV, ST_PCT_DIV: begin
                num_reg <= {num_reg[126:0], qbit};
                rem_reg <= rem_new;
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd0) begin
                    if (state_reg == ST_AREA_DIV) begin
                        ma_reg <= 64'(d_reg);
                        mb_reg <= {flast_reg[62:0], 1'b0};
                    end
                    prod_reg <= '0;
                    mk_reg   <= '0;
                end
            end
            ST_DONE: begin
                out_int_reg <= neg_reg ? (64'd0 - mag_reg) : mag_reg;
                out_abs_reg <= chg_reg[62:0];
            end
            default: ;
        endcase
        if (state_reg == ST_AREA_DIV && cnt_reg == 8'd0)
            mag_reg <= ({num_reg[126:0], qbit} > {64'd0, MAX63}) ? MAX63
                     : {num_reg[62:0], qbit};
        if (state_reg == ST_CHG_DIV && cnt_reg == 8'd0) begin
            chg_reg <= ({num_reg[126:0], qbit} > {64'd0, MAX63}) ? MAX63
                     : {num_reg[62:0], qbit};
            ma_reg   <= ({num_reg[126:0], qbit} > {64'd0, MAX63}) ? MAX63
                     : {num_reg[62:0], qbit};
            mb_reg   <= PCT_SCALE;
        end
        if (state_reg == ST_PCT_DIV && cnt_reg == 8'd0)
            out_pct_reg <= ({num_reg[126:0], qbit} > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF
                         : {num_reg[30:0], qbit};
        if (state_reg == ST_PCT_MUL && mag_reg == '0)
            out_pct_reg <= '0;
        if (state_reg == ST_AREA_DIV)
            out_pct_reg <= '0;
    end

endmodule
